[sv/atfc_pkg.sv]
// Shared types and format codes for the ARM/Thumb instruction format classifier.
// No dependencies; imported by the interfaces, the decoder and the top level.
package atfc_pkg;

    typedef logic [5:0]  fmt_t;
    typedef logic [3:0]  cond_t;
    typedef logic [31:0] instr_word_t;

    localparam fmt_t FMT_ARM_DP      = 6'd0;
    localparam fmt_t FMT_ARM_PSR     = 6'd1;
    localparam fmt_t FMT_ARM_MUL     = 6'd2;
    localparam fmt_t FMT_ARM_MULL    = 6'd3;
    localparam fmt_t FMT_ARM_SWP     = 6'd4;
    localparam fmt_t FMT_ARM_BX      = 6'd5;
    localparam fmt_t FMT_ARM_HALF    = 6'd6;
    localparam fmt_t FMT_ARM_SDT     = 6'd7;
    localparam fmt_t FMT_ARM_UNDEF   = 6'd8;
    localparam fmt_t FMT_ARM_BDT     = 6'd9;
    localparam fmt_t FMT_ARM_B       = 6'd10;
    localparam fmt_t FMT_ARM_CDT     = 6'd11;
    localparam fmt_t FMT_ARM_CDO     = 6'd12;
    localparam fmt_t FMT_ARM_CRT     = 6'd13;
    localparam fmt_t FMT_ARM_SWI     = 6'd14;

    localparam fmt_t FMT_T_SHIFT     = 6'd15;
    localparam fmt_t FMT_T_ADDSUB    = 6'd16;
    localparam fmt_t FMT_T_IMM       = 6'd17;
    localparam fmt_t FMT_T_ALU       = 6'd18;
    localparam fmt_t FMT_T_HIREG     = 6'd19;
    localparam fmt_t FMT_T_PCLOAD    = 6'd20;
    localparam fmt_t FMT_T_REGOFF    = 6'd21;
    localparam fmt_t FMT_T_SIGNEXT   = 6'd22;
    localparam fmt_t FMT_T_IMMOFF    = 6'd23;
    localparam fmt_t FMT_T_HALF      = 6'd24;
    localparam fmt_t FMT_T_SPLS      = 6'd25;
    localparam fmt_t FMT_T_LDADDR    = 6'd26;
    localparam fmt_t FMT_T_ADDSP     = 6'd27;
    localparam fmt_t FMT_T_PUSHPOP   = 6'd28;
    localparam fmt_t FMT_T_LDMSTM    = 6'd29;
    localparam fmt_t FMT_T_BCOND     = 6'd30;
    localparam fmt_t FMT_T_SWI       = 6'd31;
    localparam fmt_t FMT_T_B         = 6'd32;
    localparam fmt_t FMT_T_BL        = 6'd33;
    localparam fmt_t FMT_T_UNDEF     = 6'd34;

    localparam fmt_t FMT_FIRST_THUMB = FMT_T_SHIFT;

    localparam logic       KIND_ARM       = 1'b0;
    localparam logic       KIND_THUMB     = 1'b1;
    localparam logic [7:0] THUMB_SWI_BYTE = 8'b1101_1111;

    typedef struct packed {
        fmt_t  format_code;
        cond_t condition;
        logic  is_undefined;
    } result_t;

endpackage

[sv/atfc_if.sv]
// Valid/ready channel interfaces for instruction words and classification results.
// Depends on atfc_pkg.
interface atfc_instr_if;
    import atfc_pkg::*;

    logic        valid;
    logic        ready;
    logic        kind;
    instr_word_t instruction_word;

    modport source (output valid, output kind, output instruction_word, input ready);
    modport sink   (input valid, input kind, input instruction_word, output ready);
endinterface

interface atfc_result_if;
    import atfc_pkg::*;

    logic  valid;
    logic  ready;
    fmt_t  format_code;
    cond_t condition;
    logic  is_undefined;

    modport source (output valid, output format_code, output condition,
                    output is_undefined, input ready);
    modport sink   (input valid, input format_code, input condition,
                    input is_undefined, output ready);
endinterface

[sv/atfc_decode.sv]
// Combinational format decode for one ARM word or Thumb halfword.
// Depends on atfc_pkg.
module atfc_decode (
    input  logic                kind,
    input  atfc_pkg::instr_word_t instruction_word,
    output atfc_pkg::result_t   result
);
    import atfc_pkg::*;

    logic [2:0] arm_top;
    logic [4:0] arm_mid;
    logic [3:0] arm_low;
    logic [7:0] tb;
    fmt_t       arm_fmt;
    fmt_t       thumb_fmt;
    fmt_t       fmt;

    assign arm_top = instruction_word[27:25];
    assign arm_mid = instruction_word[24:20];
    assign arm_low = instruction_word[7:4];
    assign tb      = instruction_word[15:8];

    always_comb
    begin
        arm_fmt = FMT_ARM_DP;
        unique case (arm_top)
            3'd0:
            begin
                if (arm_mid[4])
                begin
                    priority if ((arm_mid & 5'b11011) == 5'b10000 && arm_low == 4'b1001)
                        arm_fmt = FMT_ARM_SWP;
                    else if (arm_mid == 5'b10010 && arm_low == 4'b0001)
                        arm_fmt = FMT_ARM_BX;
                    else if (arm_low[3] && arm_low[0])
                        arm_fmt = FMT_ARM_HALF;
                    else if ((arm_mid & 5'b11001) == 5'b10000)
                        arm_fmt = FMT_ARM_PSR;
                    else
                        arm_fmt = FMT_ARM_DP;
                end
                else
                begin
                    priority if (arm_mid[4:2] == 3'b000 && arm_low == 4'b1001)
                        arm_fmt = FMT_ARM_MUL;
                    else if (arm_mid[4:3] == 2'b01 && arm_low == 4'b1001)
                        arm_fmt = FMT_ARM_MULL;
                    else if (arm_low[3] && arm_low[0])
                        arm_fmt = FMT_ARM_HALF;
                    else
                        arm_fmt = FMT_ARM_DP;
                end
            end
            3'd1: arm_fmt = ((arm_mid & 5'b11001) == 5'b10000) ? FMT_ARM_PSR : FMT_ARM_DP;
            3'd2: arm_fmt = FMT_ARM_SDT;
            3'd3: arm_fmt = arm_low[0] ? FMT_ARM_UNDEF : FMT_ARM_SDT;
            3'd4: arm_fmt = FMT_ARM_BDT;
            3'd5: arm_fmt = FMT_ARM_B;
            3'd6: arm_fmt = FMT_ARM_CDT;
            3'd7:
            begin
                priority if (arm_mid[4])
                    arm_fmt = FMT_ARM_SWI;
                else if (arm_low[0])
                    arm_fmt = FMT_ARM_CRT;
                else
                    arm_fmt = FMT_ARM_CDO;
            end
            default: arm_fmt = FMT_ARM_DP;
        endcase
    end

    always_comb
    begin
        thumb_fmt = FMT_T_UNDEF;
        unique case (tb[7:5])
            3'd0: thumb_fmt = (tb[4:3] == 2'b11) ? FMT_T_ADDSUB : FMT_T_SHIFT;
            3'd1: thumb_fmt = FMT_T_IMM;
            3'd2:
            begin
                priority if (tb[4:2] == 3'd0)
                    thumb_fmt = FMT_T_ALU;
                else if (tb[4:2] == 3'd1)
                    thumb_fmt = FMT_T_HIREG;
                else if (tb[4:3] == 2'b01)
                    thumb_fmt = FMT_T_PCLOAD;
                else if (tb[1] && tb[4])
                    thumb_fmt = FMT_T_SIGNEXT;
                else
                    thumb_fmt = FMT_T_REGOFF;
            end
            3'd3: thumb_fmt = FMT_T_IMMOFF;
            3'd4: thumb_fmt = tb[4] ? FMT_T_SPLS : FMT_T_HALF;
            3'd5:
            begin
                priority if (!tb[4])
                    thumb_fmt = FMT_T_LDADDR;
                else if (tb[3:0] == 4'd0)
                    thumb_fmt = FMT_T_ADDSP;
                else if (tb[2:1] == 2'b10)
                    thumb_fmt = FMT_T_PUSHPOP;
                else
                    thumb_fmt = FMT_T_UNDEF;
            end
            3'd6:
            begin
                priority if (!tb[4])
                    thumb_fmt = FMT_T_LDMSTM;
                else if (tb == THUMB_SWI_BYTE)
                    thumb_fmt = FMT_T_SWI;
                else
                    thumb_fmt = FMT_T_BCOND;
            end
            3'd7:
            begin
                priority if (tb[4:3] == 2'b00)
                    thumb_fmt = FMT_T_B;
                else if (tb[4])
                    thumb_fmt = FMT_T_BL;
                else
                    thumb_fmt = FMT_T_UNDEF;
            end
            default: thumb_fmt = FMT_T_UNDEF;
        endcase
    end

    assign fmt = (kind == KIND_THUMB) ? thumb_fmt : arm_fmt;

    assign result.format_code  = fmt;
    assign result.condition    = (kind == KIND_THUMB) ? 4'd0 : instruction_word[31:28];
    assign result.is_undefined = (fmt == FMT_ARM_UNDEF) || (fmt == FMT_T_UNDEF);

endmodule

[sv/arm_thumb_format_classifier.sv]
// Top level of the ARM/Thumb instruction format classifier: input register,
// decode, result register. Depends on atfc_pkg, atfc_if and atfc_decode.
//
// Usage:
//   instr  : sink channel; one word per handshake carries kind (0 ARM,
//            1 Thumb) and the 32-bit instruction word (Thumb uses bits 15..0).
//   result : source channel; one word per accepted instruction with the
//            format code, the ARM condition field (0 for Thumb) and the
//            undefined-encoding flag, in input order.
//   Order:   a taken instruction waits in the input register, is decoded
//            into the result register once that register is free, and
//            is held there until the receiver takes it.
//   Throughput: one instruction per cycle when not stalled; the decode between
//            the two registers is a few levels of compare and select.
//   Reset: rst_n clears both valid flags; no word is held after reset and
//            instr.ready is high in the first cycle.
//   Stall: when result.ready is low the result word holds; the input
//            register still fills, and instr.ready drops only once both
//            registers are full. Ready rises again in the cycle the
//            receiver takes a word.
module arm_thumb_format_classifier (
    input  logic             clk,
    input  logic             rst_n,
    atfc_instr_if.sink       instr,
    atfc_result_if.source    result
);
    import atfc_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        kind_reg;
    instr_word_t word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     res_reg;
    result_t     dec_res;
    logic        out_take;
    logic        in_take;

    assign out_take = !out_valid_reg || result.ready;
    assign in_take  = !in_valid_reg || out_take;

    assign in_valid_next  = in_take ? instr.valid : in_valid_reg;
    assign out_valid_next = out_take ? in_valid_reg : out_valid_reg;

    atfc_decode u_decode (
        .kind             (kind_reg),
        .instruction_word (word_reg),
        .result           (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && instr.valid)
        begin
            kind_reg <= instr.kind;
            word_reg <= instr.instruction_word;
        end
        if (out_take && in_valid_reg)
        begin
            res_reg <= dec_res;
        end
    end

    assign instr.ready         = in_take;
    assign result.valid        = out_valid_reg;
    assign result.format_code  = res_reg.format_code;
    assign result.condition    = res_reg.condition;
    assign result.is_undefined = res_reg.is_undefined;

endmodule

[sv/atfc_checker.sv]
// Port-level checks on the classifier's result channel, bound to the top level.
// Depends on atfc_pkg and arm_thumb_format_classifier.
module atfc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input atfc_pkg::fmt_t    format_code,
    input atfc_pkg::cond_t   condition,
    input logic              is_undefined
);
    import atfc_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(format_code) && $stable(condition) && $stable(is_undefined))
        else $error("result word changed while stalled");

    a_undef_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            is_undefined == ((format_code == FMT_ARM_UNDEF) || (format_code == FMT_T_UNDEF)))
        else $error("undefined flag disagrees with format code");

    a_thumb_cond: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (format_code >= FMT_FIRST_THUMB) |-> condition == 4'd0)
        else $error("Thumb result carries a non-zero condition");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> format_code <= FMT_T_UNDEF)
        else $error("format code out of range");

endmodule

bind arm_thumb_format_classifier atfc_checker u_atfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .format_code  (result.format_code),
    .condition    (result.condition),
    .is_undefined (result.is_undefined)
);

[test/arm_thumb_format_classifier_tb.sv]
// Self-checking testbench for the ARM/Thumb instruction format classifier.
// Depends on atfc_pkg, the channel interfaces in atfc_if and the classifier top level.
`timescale 1ns / 100ps

module arm_thumb_format_classifier_tb;
    import atfc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int FORMAT_COUNT = 35;
    localparam logic [3:0] LOW_MUL = 4'b1001;
    localparam logic [3:0] LOW_BX = 4'b0001;
    localparam logic [4:0] MID_BX = 5'b10010;

    logic clk;
    logic rst_n;

    atfc_instr_if  instr_ch();
    atfc_result_if result_ch();

    arm_thumb_format_classifier DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch.sink),
        .result (result_ch.source)
    );

    result_t pending_formats[$];
    int      mismatch_count;
    int      words_sent;
    int      results_seen;
    int      cycle_count;
    bit      idle_enabled;
    int      format_hits[FORMAT_COUNT];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic result_t predict_format(logic k, instr_word_t w);
        result_t    r;
        fmt_t       f;
        logic [2:0] top;
        logic [4:0] mid;
        logic [3:0] low;
        logic [7:0] hb;
        top = w[27:25];
        mid = w[24:20];
        low = w[7:4];
        hb  = w[15:8];
        if (k == KIND_THUMB)
        begin
            case (hb[7:5])
                3'd0: f = (hb[4:3] == 2'b11) ? FMT_T_ADDSUB : FMT_T_SHIFT;
                3'd1: f = FMT_T_IMM;
                3'd2:
                begin
                    if (hb[4:2] == 3'd0)
                        f = FMT_T_ALU;
                    else if (hb[4:2] == 3'd1)
                        f = FMT_T_HIREG;
                    else if (hb[4:3] == 2'b01)
                        f = FMT_T_PCLOAD;
                    else if (hb[1] && hb[4])
                        f = FMT_T_SIGNEXT;
                    else
                        f = FMT_T_REGOFF;
                end
                3'd3: f = FMT_T_IMMOFF;
                3'd4: f = hb[4] ? FMT_T_SPLS : FMT_T_HALF;
                3'd5:
                begin
                    if (!hb[4])
                        f = FMT_T_LDADDR;
                    else if (hb[3:0] == 4'd0)
                        f = FMT_T_ADDSP;
                    else if (hb[2:1] == 2'b10)
                        f = FMT_T_PUSHPOP;
                    else
                        f = FMT_T_UNDEF;
                end
                3'd6:
                begin
                    if (!hb[4])
                        f = FMT_T_LDMSTM;
                    else if (hb == THUMB_SWI_BYTE)
                        f = FMT_T_SWI;
                    else
                        f = FMT_T_BCOND;
                end
                default:
                begin
                    if (hb[4:3] == 2'b00)
                        f = FMT_T_B;
                    else if (hb[4])
                        f = FMT_T_BL;
                    else
                        f = FMT_T_UNDEF;
                end
            endcase
            r.condition = '0;
        end
        else
        begin
            case (top)
                3'd0:
                begin
                    if (mid[4])
                    begin
                        if ((mid & 5'b11011) == 5'b10000 && low == LOW_MUL)
                            f = FMT_ARM_SWP;
                        else if (mid == MID_BX && low == LOW_BX)
                            f = FMT_ARM_BX;
                        else if (low[3] && low[0])
                            f = FMT_ARM_HALF;
                        else if ((mid & 5'b11001) == 5'b10000)
                            f = FMT_ARM_PSR;
                        else
                            f = FMT_ARM_DP;
                    end
                    else if (mid[4:2] == 3'd0 && low == LOW_MUL)
                        f = FMT_ARM_MUL;
                    else if (mid[4:3] == 2'b01 && low == LOW_MUL)
                        f = FMT_ARM_MULL;
                    else if (low[3] && low[0])
                        f = FMT_ARM_HALF;
                    else
                        f = FMT_ARM_DP;
                end
                3'd1: f = ((mid & 5'b11001) == 5'b10000) ? FMT_ARM_PSR : FMT_ARM_DP;
                3'd2: f = FMT_ARM_SDT;
                3'd3: f = low[0] ? FMT_ARM_UNDEF : FMT_ARM_SDT;
                3'd4: f = FMT_ARM_BDT;
                3'd5: f = FMT_ARM_B;
                3'd6: f = FMT_ARM_CDT;
                default:
                begin
                    if (mid[4])
                        f = FMT_ARM_SWI;
                    else
                        f = low[0] ? FMT_ARM_CRT : FMT_ARM_CDO;
                end
            endcase
            r.condition = w[31:28];
        end
        r.format_code  = f;
        r.is_undefined = (f == FMT_ARM_UNDEF) || (f == FMT_T_UNDEF);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (!idle_enabled || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic instr_word_t arm_word_of(fmt_t f);
        logic [31:0] rnd;
        logic [2:0]  top;
        logic [4:0]  mid;
        logic [3:0]  low;
        rnd = $urandom;
        top = rnd[27:25];
        mid = rnd[24:20];
        low = rnd[7:4];
        case (f)
            FMT_ARM_DP:
            begin
                top = 3'd1;
                mid[0] = 1'b1;
            end
            FMT_ARM_PSR:
            begin
                top = {2'b00, rnd[8]};
                mid = {2'b10, mid[2:1], 1'b0};
                low[0] = 1'b0;
            end
            FMT_ARM_MUL:
            begin
                top = 3'd0;
                mid[4:2] = 3'd0;
                low = LOW_MUL;
            end
            FMT_ARM_MULL:
            begin
                top = 3'd0;
                mid[4:3] = 2'b01;
                low = LOW_MUL;
            end
            FMT_ARM_SWP:
            begin
                top = 3'd0;
                mid = {2'b10, mid[2], 2'b00};
                low = LOW_MUL;
            end
            FMT_ARM_BX:
            begin
                top = 3'd0;
                mid = MID_BX;
                low = LOW_BX;
            end
            FMT_ARM_HALF:
            begin
                top = 3'd0;
                low = {1'b1, 2'($urandom_range(3, 1)), 1'b1};
            end
            FMT_ARM_SDT:
            begin
                top = {2'b01, rnd[8]};
                low[0] = 1'b0;
            end
            FMT_ARM_UNDEF:
            begin
                top = 3'd3;
                low[0] = 1'b1;
            end
            FMT_ARM_BDT: top = 3'd4;
            FMT_ARM_B:   top = 3'd5;
            FMT_ARM_CDT: top = 3'd6;
            FMT_ARM_CDO:
            begin
                top = 3'd7;
                mid[4] = 1'b0;
                low[0] = 1'b0;
            end
            FMT_ARM_CRT:
            begin
                top = 3'd7;
                mid[4] = 1'b0;
                low[0] = 1'b1;
            end
            default:
            begin
                top = 3'd7;
                mid[4] = 1'b1;
            end
        endcase
        return {rnd[31:28], top, mid, rnd[19:8], low, rnd[3:0]};
    endfunction

    function automatic instr_word_t thumb_word_of(fmt_t f);
        logic [31:0] rnd;
        logic [7:0]  b;
        logic [3:0]  n;
        rnd = $urandom;
        b = rnd[15:8];
        case (f)
            FMT_T_SHIFT:   b = {3'b000, 2'($urandom_range(2, 0)), b[2:0]};
            FMT_T_ADDSUB:  b = {5'b00011, b[2:0]};
            FMT_T_IMM:     b = {3'b001, b[4:0]};
            FMT_T_ALU:     b = {6'b010000, b[1:0]};
            FMT_T_HIREG:   b = {6'b010001, b[1:0]};
            FMT_T_PCLOAD:  b = {5'b01001, b[2:0]};
            FMT_T_SIGNEXT: b = {4'b0101, b[3:2], 1'b1, b[0]};
            FMT_T_REGOFF:  b = {4'b0101, b[3:2], 1'b0, b[0]};
            FMT_T_IMMOFF:  b = {3'b011, b[4:0]};
            FMT_T_HALF:    b = {4'b1000, b[3:0]};
            FMT_T_SPLS:    b = {4'b1001, b[3:0]};
            FMT_T_LDADDR:  b = {4'b1010, b[3:0]};
            FMT_T_ADDSP:   b = 8'b1011_0000;
            FMT_T_PUSHPOP: b = {4'b1011, b[3], 2'b10, b[0]};
            FMT_T_LDMSTM:  b = {4'b1100, b[3:0]};
            FMT_T_SWI:     b = THUMB_SWI_BYTE;
            FMT_T_BCOND:
            begin
                do
                    b = {4'b1101, 4'($urandom)};
                while (b == THUMB_SWI_BYTE);
            end
            FMT_T_B:       b = {5'b11100, b[2:0]};
            FMT_T_BL:      b = {4'b1111, b[3:0]};
            default:
            begin
                if (rnd[16])
                    b = {5'b11101, b[2:0]};
                else
                begin
                    do
                        n = 4'($urandom);
                    while (n == 4'd0 || n[2:1] == 2'b10);
                    b = {4'b1011, n};
                end
            end
        endcase
        return {rnd[31:16], b, rnd[7:0]};
    endfunction

    task automatic send_word(input logic k, input instr_word_t w);
        int  gap;
        bit  taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_ch.valid            <= 1'b1;
        instr_ch.kind             <= k;
        instr_ch.instruction_word <= w;
        forever
        begin
            @(negedge clk);
            taken = instr_ch.ready;
            @(posedge clk);
            if (taken)
                break;
        end
        pending_formats.push_back(predict_format(k, w));
        words_sent++;
    endtask

    task automatic send_format(input fmt_t f);
        if (f < FMT_FIRST_THUMB)
            send_word(KIND_ARM, arm_word_of(f));
        else
            send_word(KIND_THUMB, thumb_word_of(f));
    endtask

    task automatic send_random_word();
        if ($urandom_range(9, 0) < 6)
            send_format(fmt_t'($urandom_range(FORMAT_COUNT - 1, 0)));
        else
            send_word(1'($urandom), $urandom);
    endtask

    task automatic wait_for_results();
        while (pending_formats.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_field_extremes();
        send_word(KIND_ARM, 32'h0000_0000);
        send_word(KIND_ARM, 32'hFFFF_FFFF);
        send_word(KIND_THUMB, 32'h0000_0000);
        send_word(KIND_THUMB, 32'hFFFF_FFFF);
    endtask

    task automatic test_condition_field();
        send_word(KIND_ARM, 32'hFA00_0000);
        send_word(KIND_ARM, 32'hF000_0090);
        send_word(KIND_ARM, 32'h0E10_0010);
        send_word(KIND_ARM, 32'hE12F_FF1E);
    endtask

    task automatic test_thumb_corner_cases();
        send_word(KIND_THUMB, 32'h0000_DE00);
        send_word(KIND_THUMB, 32'h0000_DF00);
        send_word(KIND_THUMB, 32'hFFFF_DFFF);
        send_word(KIND_THUMB, 32'hA5A5_DEFF);
        send_word(KIND_THUMB, 32'hFFFF_4770);
        send_word(KIND_THUMB, 32'h0000_B100);
        send_word(KIND_THUMB, 32'h0000_E800);
        send_word(KIND_ARM, 32'hE600_0010);
    endtask

    task automatic test_every_format();
        for (int pass = 0; pass < 2; pass++)
            for (int f = 0; f < FORMAT_COUNT; f++)
                send_format(fmt_t'(f));
    endtask

    task automatic test_back_to_back();
        idle_enabled = 1'b0;
        repeat (100) send_random_word();
        idle_enabled = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (20) send_random_word();
        instr_ch.valid <= 1'b0;
        wait_for_results();
        @(posedge clk);
        repeat (20) send_random_word();
    endtask

    task automatic test_random_mix();
        repeat (540) send_random_word();
    endtask

    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            int stall;
            stall = pick_gap();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    end

    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (result_ch.format_code < FORMAT_COUNT)
                format_hits[result_ch.format_code]++;
            if (pending_formats.size() == 0)
            begin
                $error("result word with no instruction pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_formats.pop_front();
                if (result_ch.format_code !== want.format_code)
                begin
                    $error("format_code: expected %0d, got %0d",
                           want.format_code, result_ch.format_code);
                    mismatch_count++;
                end
                if (result_ch.condition !== want.condition)
                begin
                    $error("condition: expected %0d, got %0d",
                           want.condition, result_ch.condition);
                    mismatch_count++;
                end
                if (result_ch.is_undefined !== want.is_undefined)
                begin
                    $error("is_undefined: expected %0b, got %0b",
                           want.is_undefined, result_ch.is_undefined);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int distinct;
        mismatch_count = 0;
        words_sent     = 0;
        results_seen   = 0;
        cycle_count    = 0;
        idle_enabled   = 1'b1;
        distinct       = 0;
        foreach (format_hits[i])
            format_hits[i] = 0;
        rst_n                     <= 1'b0;
        instr_ch.valid            <= 1'b0;
        instr_ch.kind             <= KIND_ARM;
        instr_ch.instruction_word <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_condition_field();
        test_thumb_corner_cases();
        test_every_format();
        test_back_to_back();
        test_drain_pause();
        test_random_mix();

        instr_ch.valid <= 1'b0;
        wait_for_results();
        repeat (10) @(posedge clk);

        foreach (format_hits[i])
            if (format_hits[i] != 0)
                distinct++;
        $display("Sent %0d ARM/Thumb words, checked %0d results, %0d mismatches",
                 words_sent, results_seen, mismatch_count);
        $display("Distinct format codes observed: %0d of %0d", distinct, FORMAT_COUNT);
        if (mismatch_count == 0 && pending_formats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
